// ----- hw/rtl/row_decimate_five_tap_filter_macros.svh -----
// assertion helpers for the row decimate filter
`ifndef ROW_DECIMATE_FIVE_TAP_FILTER_MACROS_SVH
`define ROW_DECIMATE_FIVE_TAP_FILTER_MACROS_SVH

// same-cycle implication, checked outside reset
`define RDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define RDF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rdf_pkg.sv -----
`default_nettype none

package rdf_pkg;

    // fixed field widths
    localparam int C_PIX_W = 8;
    localparam int C_CFG_W = 13;

    // row width limits and reset value
    localparam int C_MAX_WIDTH       = 4096;
    localparam int C_MIN_WIDTH       = 10;
    localparam int C_ROW_WIDTH_RESET = 640;

    // the last filtered column sits this far before the row end, rounded to odd
    localparam int C_TAIL_COLS = 6;
    // first column that carries a filtered output
    localparam int C_FIRST_FILT_COL = 5;

    // filter arithmetic
    localparam int C_SUM_W = 19;
    localparam logic signed [C_SUM_W-1:0] C_TAP_OUTER  = -19'sd29;
    localparam logic signed [C_SUM_W-1:0] C_TAP_INNER  = 19'sd88;
    localparam logic signed [C_SUM_W-1:0] C_TAP_CENTER = 19'sd138;
    // sum is scaled down by 256
    localparam int C_SHIFT = 8;

    // one filter job: five taps plus flags
    typedef struct packed {
        logic [C_PIX_W-1:0] tap_a;
        logic [C_PIX_W-1:0] tap_b;
        logic [C_PIX_W-1:0] tap_c;
        logic [C_PIX_W-1:0] tap_d;
        logic [C_PIX_W-1:0] tap_e;
        logic               bypass;
        logic               row_end;
    } t_taps;

endpackage

`default_nettype wire

// ----- hw/rtl/rdf_out_stage.sv -----
`default_nettype none

module rdf_out_stage import rdf_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire t_taps              i_taps,
    output logic                    o_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [C_PIX_W-1:0]      o_filtered_pixel,
    output logic                    o_row_end
);

    logic                      r_valid;
    logic [C_PIX_W-1:0]        r_pixel;
    logic                      r_row_end;
    logic [C_PIX_W:0]          sum_ae;
    logic [C_PIX_W:0]          sum_bd;
    logic signed [C_SUM_W-1:0] sum;
    logic [C_PIX_W-1:0]        filt;
    logic [C_PIX_W-1:0]        n_pixel;

    // output register is free or being drained this cycle
    assign o_ready = !r_valid || !i_out_stall;

    // weighted sum, symmetric taps paired first
    always_comb begin
        sum_ae = {1'b0, i_taps.tap_a} + {1'b0, i_taps.tap_e};
        sum_bd = {1'b0, i_taps.tap_b} + {1'b0, i_taps.tap_d};
        sum = C_TAP_OUTER * $signed({{(C_SUM_W-C_PIX_W-1){1'b0}}, sum_ae})
            + C_TAP_INNER * $signed({{(C_SUM_W-C_PIX_W-1){1'b0}}, sum_bd})
            + C_TAP_CENTER * $signed({{(C_SUM_W-C_PIX_W){1'b0}}, i_taps.tap_c});
    end

    // clamp to 0..255 after the scale down
    always_comb begin
        if (sum[C_SUM_W-1]) begin
            filt = '0;
        end else if (|sum[C_SUM_W-2:C_SHIFT+C_PIX_W]) begin
            filt = '1;
        end else begin
            filt = sum[C_SHIFT+C_PIX_W-1:C_SHIFT];
        end
        n_pixel = i_taps.bypass ? i_taps.tap_e : filt;
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel   <= n_pixel;
            r_row_end <= i_taps.row_end;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_filtered_pixel = r_pixel;
    assign o_row_end        = r_row_end;

endmodule

`default_nettype wire

// ----- hw/rtl/row_decimate_five_tap_filter.sv -----
// path: an accepted pixel is registered in the stage register, then its result in the output register
// throughput: one pixel per cycle when the output is not stalled; the window and
// column counter advance on every accepted pixel
// reset: synchronous active low; clears the pixel window, column counter and
// pipeline valids, and sets the row width to 640
`default_nettype none

module row_decimate_five_tap_filter import rdf_pkg::*; #(
    parameter int MAX_WIDTH = C_MAX_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // pixel input
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [C_PIX_W-1:0] i_pixel,
    // result output
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [C_PIX_W-1:0]      o_filtered_pixel,
    output logic                    o_row_end,
    // row width register write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [C_CFG_W-1:0] i_cfg_row_width
);

    localparam int CntW = $clog2(MAX_WIDTH);
    localparam int WidW = (C_CFG_W > $clog2(MAX_WIDTH + 1)) ? C_CFG_W
                                                            : $clog2(MAX_WIDTH + 1);

    logic [C_CFG_W-1:0] r_row_width;
    logic [CntW-1:0]    r_col;
    logic [CntW-1:0]    n_col;
    logic [C_PIX_W-1:0] r_win [6];
    logic               r_s1_valid;
    t_taps              r_s1_taps;
    t_taps              n_taps;

    logic [WidW-1:0]    eff_width;
    logic [WidW-1:0]    last_col;
    logic [WidW-1:0]    col_ext;
    logic               is_first;
    logic               is_filt;
    logic               s1_load;
    logic               in_accept;
    logic               out_ready;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // effective width and last filtered column
    always_comb begin
        if (WidW'(r_row_width) < WidW'(C_MIN_WIDTH)) begin
            eff_width = WidW'(C_MIN_WIDTH);
        end else if (WidW'(r_row_width) > WidW'(MAX_WIDTH)) begin
            eff_width = WidW'(MAX_WIDTH);
        end else begin
            eff_width = WidW'(r_row_width);
        end
        last_col = (eff_width - WidW'(C_TAIL_COLS)) | WidW'(1);
    end

    // column decode and next column
    always_comb begin
        col_ext  = WidW'(r_col);
        is_first = (col_ext == WidW'(1));
        is_filt  = r_col[0] && (col_ext >= WidW'(C_FIRST_FILT_COL))
                   && (col_ext <= last_col);
        if ((col_ext + WidW'(1)) >= eff_width) begin
            n_col = '0;
        end else begin
            n_col = r_col + CntW'(1);
        end
    end

    // taps for the filter job
    always_comb begin
        n_taps.tap_a   = r_win[5];
        n_taps.tap_b   = r_win[3];
        n_taps.tap_c   = r_win[2];
        n_taps.tap_d   = r_win[1];
        n_taps.tap_e   = i_pixel;
        n_taps.bypass  = is_first;
        n_taps.row_end = is_filt && (col_ext == last_col);
    end

    // input handshake
    assign s1_load    = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_load;
    assign in_accept  = i_in_valid && s1_load;

    // control state: width register, column counter, window, stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= C_CFG_W'(C_ROW_WIDTH_RESET);
            r_col       <= '0;
            r_s1_valid  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_row_width <= i_cfg_row_width;
            end
            if (in_accept) begin
                r_col    <= n_col;
                r_win[0] <= i_pixel;
                for (int k = 1; k < 6; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
            if (s1_load) begin
                r_s1_valid <= in_accept && (is_first || is_filt);
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_taps <= n_taps;
        end
    end

    // filter arithmetic and output register
    rdf_out_stage u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (r_s1_valid),
        .i_taps           (r_s1_taps),
        .o_ready          (out_ready),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_filtered_pixel (o_filtered_pixel),
        .o_row_end        (o_row_end)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/rdf_checker.sv -----
`default_nettype none

`include "row_decimate_five_tap_filter_macros.svh"

module rdf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_filtered_pixel,
    input wire logic       o_row_end
);

    // a result held back by the sink stays offered
    `RDF_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped under stall")

    // a held result does not change
    `RDF_ASSERT_NXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_filtered_pixel) && $stable(o_row_end), "result changed under stall")

    // input only backs up when both pipeline stages are full and blocked
    `RDF_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled without a blocked output")

    // a fresh result comes from an input transaction through the stage and output registers
    `RDF_ASSERT_NOW(a_out_source, $rose(o_out_valid), $past(i_in_valid && !o_in_stall, 2), "result without an input transaction")

endmodule

bind row_decimate_five_tap_filter rdf_checker u_rdf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_filtered_pixel (o_filtered_pixel),
    .o_row_end        (o_row_end)
);

`default_nettype wire
